/* rtl/core/divisible_subarray_counter_top_macros.svh */
// Assertion macros used by the port-level checker of the divisible-run counter.
// Depends on signals named clock and reset in the scope of each use.
`ifndef DIVISIBLE_SUBARRAY_COUNTER_TOP_MACROS_SVH
`define DIVISIBLE_SUBARRAY_COUNTER_TOP_MACROS_SVH

// Check a condition at every edge outside reset
`define DSC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle
`define DSC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the antecedent implies the consequent in the next cycle
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/dsc_pkg.sv */
// Shared types, widths and constants of the divisible-run counter.
// No dependencies; the files that use it refer to it by scoped names.
package dsc_pkg;

   localparam int unsigned MAX_MODULUS = 65536;
   localparam int unsigned ADDR_W      = $clog2(MAX_MODULUS);
   localparam int unsigned RES_W       = ADDR_W;
   localparam int unsigned MOD_W       = 17;
   localparam int unsigned BOX_W       = 20;
   localparam int unsigned SUM_W       = 21;
   localparam int unsigned WAYS_W      = 25;
   localparam int unsigned CNT_W       = 17;
   localparam int unsigned EPOCH_W     = 8;
   localparam int unsigned BITCNT_W    = $clog2(SUM_W);

   localparam logic [WAYS_W-1:0]   WAYS_MOD  = 25'd20091101;
   localparam logic [CNT_W-1:0]    SAT_CNT   = 17'h1FFFF;
   localparam logic [MOD_W-1:0]    MOD_LIMIT = MOD_W'(MAX_MODULUS);
   localparam logic [MOD_W-1:0]    MOD_RESET = 17'd1;
   localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = 8'd1;
   localparam logic [BITCNT_W-1:0] LAST_BIT  = BITCNT_W'(SUM_W - 1);

   typedef struct packed {
      logic [BOX_W-1:0] box_count;
      logic             first_of_case;
      logic             last_of_case;
   } req_type;

   typedef struct packed {
      logic [WAYS_W-1:0] ways;
      logic [CNT_W-1:0]  max_orders;
   } rsp_type;

   // One residue table entry; valid only while its tag equals the case epoch
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [CNT_W-1:0]   occ;
      logic [CNT_W-1:0]   best;
   } mem_word_type;

   localparam int unsigned MEM_W = $bits(mem_word_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEED,
      ST_LOAD,
      ST_DIV,
      ST_READ,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              clear_en;
      logic [ADDR_W-1:0] clear_addr;
      logic              seed;
      logic              load;
      logic              div_step;
      logic              read;
      logic              update;
      logic              emit;
   } cmd_type;

   typedef struct packed {
      logic first_in;
      logic last;
      logic epoch_full;
   } status_type;

endpackage

/* rtl/core/dsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dsc_ctrl.sv */
// Sequencer of the divisible-run counter: handshakes, clearing pass, division steps.
// Depends on dsc_pkg.
module dsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  dsc_pkg::status_type status,
   output dsc_pkg::cmd_type    cmd
);

   dsc_pkg::state_type             state_ff, state_in;
   logic [dsc_pkg::ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [dsc_pkg::BITCNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                           seed_pend_ff, seed_pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsc_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         seed_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         seed_pend_ff <= seed_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      seed_pend_in = seed_pend_ff;
      cmd          = '0;
      cmd.clear_addr = clr_cnt_ff;
      req_stall    = 1'b1;

      unique case (state_ff)
         dsc_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               seed_pend_in = 1'b0;
               state_in     = seed_pend_ff ? dsc_pkg::ST_SEED : dsc_pkg::ST_IDLE;
            end
         end
         dsc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.first_in && status.epoch_full) begin
                  seed_pend_in = 1'b1;
                  state_in     = dsc_pkg::ST_CLEAR;
               end else if (status.first_in) begin
                  state_in = dsc_pkg::ST_SEED;
               end else begin
                  state_in = dsc_pkg::ST_LOAD;
               end
            end
         end
         dsc_pkg::ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = dsc_pkg::ST_LOAD;
         end
         dsc_pkg::ST_LOAD: begin
            cmd.load   = 1'b1;
            bit_cnt_in = '0;
            state_in   = dsc_pkg::ST_DIV;
         end
         dsc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == dsc_pkg::LAST_BIT) begin
               state_in = dsc_pkg::ST_READ;
            end
         end
         dsc_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = dsc_pkg::ST_UPDATE;
         end
         dsc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last ? dsc_pkg::ST_EMIT : dsc_pkg::ST_IDLE;
         end
         dsc_pkg::ST_EMIT: begin
            // Hold until the result register is free or drains this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = dsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsc_pkg::ST_IDLE;
         end
      endcase
   end

   // Result beat valid: set when the result register is loaded, drop once taken
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

/* rtl/core/dsc_dpath.sv */
// Datapath of the divisible-run counter: residue remainder unit, totals, residue table.
// Depends on dsc_pkg and dsc_ram.
module dsc_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  dsc_pkg::cmd_type           cmd,
   output dsc_pkg::status_type        status,
   input  dsc_pkg::req_type           req_data,
   output dsc_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [dsc_pkg::MOD_W-1:0]  csr_wr_data
);

   logic [dsc_pkg::MOD_W-1:0]   modulus_ff, modulus_in;
   logic [dsc_pkg::MOD_W-1:0]   eff_mod;
   dsc_pkg::req_type            req_ff;
   logic [dsc_pkg::EPOCH_W-1:0] epoch_ff, epoch_in, epoch_next;
   logic [dsc_pkg::RES_W-1:0]   residue_ff, residue_in;
   logic [dsc_pkg::WAYS_W-1:0]  ways_ff, ways_in;
   logic [dsc_pkg::CNT_W-1:0]   best_ff, best_in;
   logic [dsc_pkg::SUM_W-1:0]   dividend_ff, dividend_in;
   logic [dsc_pkg::RES_W-1:0]   rem_ff, rem_in;
   dsc_pkg::rsp_type            rsp_ff;

   logic [dsc_pkg::RES_W:0]     shifted;
   dsc_pkg::mem_word_type       rd_word, wr_word, upd_word;
   logic [dsc_pkg::MEM_W-1:0]   rd_bits;
   logic                        wr_en;
   logic [dsc_pkg::ADDR_W-1:0]  wr_addr;
   logic                        hit;
   logic [dsc_pkg::CNT_W-1:0]   occ, occ_new, cand, cur;
   logic [dsc_pkg::WAYS_W:0]    ways_sum;
   logic [dsc_pkg::WAYS_W-1:0]  ways_upd;

   // Clamp the divisor to 1..MAX_MODULUS
   always_comb begin
      if (modulus_ff == '0) begin
         eff_mod = dsc_pkg::MOD_W'(1);
      end else if (modulus_ff > dsc_pkg::MOD_LIMIT) begin
         eff_mod = dsc_pkg::MOD_LIMIT;
      end else begin
         eff_mod = modulus_ff;
      end
   end

   assign modulus_in = csr_wr_en ? csr_wr_data : modulus_ff;
   assign epoch_next = (epoch_ff == '1) ? dsc_pkg::EPOCH_FIRST : epoch_ff + 1'b1;

   // One restoring remainder step per cycle
   assign shifted = {rem_ff, dividend_ff[dsc_pkg::SUM_W-1]};

   // Table entry update
   assign rd_word = dsc_pkg::mem_word_type'(rd_bits);
   assign hit     = (rd_word.tag == epoch_ff);
   assign occ     = hit ? rd_word.occ : '0;
   assign occ_new = (occ == dsc_pkg::SAT_CNT) ? occ : occ + 1'b1;
   assign cand    = (rd_word.best == dsc_pkg::SAT_CNT) ? rd_word.best : rd_word.best + 1'b1;
   assign cur     = (hit && (cand > best_ff)) ? cand : best_ff;
   assign ways_sum = {1'b0, ways_ff} + (dsc_pkg::WAYS_W+1)'(occ);
   assign ways_upd = (ways_sum >= {1'b0, dsc_pkg::WAYS_MOD})
                     ? dsc_pkg::WAYS_W'(ways_sum - {1'b0, dsc_pkg::WAYS_MOD})
                     : ways_sum[dsc_pkg::WAYS_W-1:0];

   always_comb begin
      upd_word.tag  = epoch_ff;
      upd_word.occ  = occ_new;
      upd_word.best = cur;
   end

   // Working registers
   always_comb begin
      epoch_in    = epoch_ff;
      residue_in  = residue_ff;
      ways_in     = ways_ff;
      best_in     = best_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;

      if (cmd.seed) begin
         epoch_in   = epoch_next;
         residue_in = '0;
         ways_in    = '0;
         best_in    = '0;
      end
      if (cmd.load) begin
         dividend_in = dsc_pkg::SUM_W'(residue_ff) + dsc_pkg::SUM_W'(req_ff.box_count);
         rem_in      = '0;
      end
      if (cmd.div_step) begin
         dividend_in = {dividend_ff[dsc_pkg::SUM_W-2:0], 1'b0};
         if (shifted >= eff_mod) begin
            rem_in = dsc_pkg::RES_W'(shifted - eff_mod);
         end else begin
            rem_in = dsc_pkg::RES_W'(shifted);
         end
      end
      if (cmd.read) begin
         residue_in = rem_ff;
      end
      if (cmd.update) begin
         ways_in = ways_upd;
         best_in = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= dsc_pkg::MOD_RESET;
         epoch_ff   <= dsc_pkg::EPOCH_FIRST;
         residue_ff <= '0;
         ways_ff    <= '0;
         best_ff    <= '0;
      end else begin
         modulus_ff <= modulus_in;
         epoch_ff   <= epoch_in;
         residue_ff <= residue_in;
         ways_ff    <= ways_in;
         best_ff    <= best_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.emit) begin
         rsp_ff.ways       <= ways_ff;
         rsp_ff.max_orders <= best_ff;
      end
   end

   // Table write select: clearing pass, case seed, or entry update
   always_comb begin
      wr_en   = cmd.clear_en | cmd.seed | cmd.update;
      wr_addr = residue_ff;
      wr_word = upd_word;
      if (cmd.clear_en) begin
         wr_addr = cmd.clear_addr;
         wr_word = '0;
      end else if (cmd.seed) begin
         wr_addr      = '0;
         wr_word.tag  = epoch_next;
         wr_word.occ  = dsc_pkg::CNT_W'(1);
         wr_word.best = '0;
      end
   end

   dsc_ram #(
      .WIDTH (dsc_pkg::MEM_W),
      .DEPTH (dsc_pkg::MAX_MODULUS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (cmd.read),
      .rd_addr (rem_ff),
      .rd_data (rd_bits)
   );

   assign status.first_in   = req_data.first_of_case;
   assign status.last       = req_ff.last_of_case;
   assign status.epoch_full = (epoch_ff == '1);
   assign rsp_data          = rsp_ff;

endmodule

/* rtl/core/divisible_subarray_counter_top.sv */
// Top level of the divisible-run counter.
// Depends on dsc_pkg, dsc_ctrl, dsc_dpath (and through it dsc_ram).
//
// Takes one value per beat and keeps the prefix sum modulo csr_wr_data's divisor;
// on a beat marked last it returns the count of divisible runs (mod 20091101) and
// the most non-overlapping divisible runs. One item is worked at a time: an
// ordinary item goes through acceptance, load, 21 steps of the bit-serial
// remainder unit, table read and table write before the next ready; a first item
// adds the residue-zero seed, and a last item adds loading the result register.
// The remainder unit and the single read/write of the 64K-entry residue table
// set the pace. After reset the block runs a clearing pass over all 65536 table
// entries with req_stall high; each case start uses a new table epoch, and every
// 255th case start repeats the clearing pass before the item proceeds.
// A finished result waits in its output register while the next item is worked.
module divisible_subarray_counter_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dsc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dsc_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [dsc_pkg::MOD_W-1:0] csr_wr_data
);

   dsc_pkg::cmd_type    cmd;
   dsc_pkg::status_type status;

   dsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dsc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

/* rtl/core/dsc_checker.sv */
// Port-level checks of the divisible-run counter, bound to its top level.
// Depends on dsc_pkg and divisible_subarray_counter_top_macros.svh.
`include "divisible_subarray_counter_top_macros.svh"

module dsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dsc_pkg::rsp_type rsp_data
);

   // A stalled result beat holds
   `DSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp moved")

   // An accepted item keeps the input stalled while it is worked
   `DSC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "req ready early")

   // The run count stays reduced
   `DSC_ASSERT_IMP(a_ways_range, rsp_valid, rsp_data.ways < dsc_pkg::WAYS_MOD, "ways unreduced")

   // A result only follows a busy cycle
   `DSC_ASSERT_IMP(a_rsp_after_work, $rose(rsp_valid), $past(req_stall), "result without work")

   // Clearing pass holds the input after reset
   `DSC_ASSERT_ALWAYS(a_clear_after_reset, !$past(reset) || req_stall, "req ready in clear")

endmodule

bind divisible_subarray_counter_top dsc_checker u_dsc_checker (.*);

/* verif/divisible_subarray_counter_checker.sv */
// Checker for the divisible-run counter: watches the request, result and csr channels,
// keeps its own prefix-residue tables and compares every result beat with its prediction.
// Depends on dsc_pkg for the beat types and port widths.
`timescale 1ns / 100ps

module divisible_subarray_counter_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  dsc_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  dsc_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [dsc_pkg::MOD_W-1:0] csr_wr_data,
   output int unsigned               mismatch_count,
   output int unsigned               tallies_waiting
);

   localparam int unsigned TOP_MODULUS = 65536;
   localparam int unsigned RUN_MOD     = 20091101;
   localparam int unsigned COUNT_CAP   = 131071;

   int unsigned divisor;
   int unsigned prefix_residue;
   int unsigned run_count;
   int unsigned disjoint_best;
   int unsigned occ_tbl[int unsigned];
   bit          seen_tbl[int unsigned];
   int unsigned best_tbl[int unsigned];

   dsc_pkg::rsp_type expected_tallies[$];

   initial begin
      mismatch_count  = 0;
      tallies_waiting = 0;
   end

   task automatic flag_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   // Fold one request beat into the residue tables; queue a tally on the last beat
   task automatic count_runs(input dsc_pkg::req_type item);
      int unsigned      m;
      int unsigned      r;
      int unsigned      hits;
      int unsigned      cur;
      int unsigned      cand;
      dsc_pkg::rsp_type tally;
      m = divisor;
      if (m == 0) m = 1;
      if (m > TOP_MODULUS) m = TOP_MODULUS;

      // Start a case: empty the occupancy and seen tables and seed residue zero
      if (item.first_of_case) begin
         occ_tbl.delete();
         seen_tbl.delete();
         prefix_residue = 0;
         run_count      = 0;
         disjoint_best  = 0;
         occ_tbl[0]     = 1;
         seen_tbl[0]    = 1'b1;
         best_tbl[0]    = 0;
      end

      r = (prefix_residue + item.box_count) % m;
      prefix_residue = r;

      // Every earlier prefix with this residue closes one divisible run
      hits = occ_tbl.exists(r) ? occ_tbl[r] : 0;
      run_count = (run_count + hits) % RUN_MOD;
      if (hits < COUNT_CAP) occ_tbl[r] = hits + 1;

      // Best disjoint total: extend from the last prefix with this residue
      cur = disjoint_best;
      if (seen_tbl.exists(r)) begin
         cand = best_tbl[r];
         if (cand < COUNT_CAP) cand++;
         if (cand > cur) cur = cand;
      end
      best_tbl[r]   = cur;
      seen_tbl[r]   = 1'b1;
      disjoint_best = cur;

      if (item.last_of_case) begin
         tally.ways       = run_count[dsc_pkg::WAYS_W-1:0];
         tally.max_orders = disjoint_best[dsc_pkg::CNT_W-1:0];
         expected_tallies.push_back(tally);
      end
   endtask

   // Sample all channels at the rising edge
   always @(posedge clock) begin
      dsc_pkg::rsp_type want;
      if (reset) begin
         divisor        = 1;
         prefix_residue = 0;
         run_count      = 0;
         disjoint_best  = 0;
         occ_tbl.delete();
         seen_tbl.delete();
         best_tbl.delete();
         expected_tallies.delete();
      end else begin
         if (csr_wr_en) divisor = csr_wr_data;
         if (req_valid && !req_stall) count_runs(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_tallies.size() == 0) begin
               flag_mismatch($sformatf("result beat ways=%0d max_orders=%0d with none pending",
                                       rsp_data.ways, rsp_data.max_orders));
            end else begin
               want = expected_tallies.pop_front();
               if (rsp_data.ways !== want.ways)
                  flag_mismatch($sformatf("ways got %0d want %0d",
                                          rsp_data.ways, want.ways));
               if (rsp_data.max_orders !== want.max_orders)
                  flag_mismatch($sformatf("max_orders got %0d want %0d",
                                          rsp_data.max_orders, want.max_orders));
            end
         end
      end
      tallies_waiting = expected_tallies.size();
   end

endmodule

/* verif/divisible_subarray_counter_top_tb.sv */
// Testbench top for the divisible-run counter: clock, reset, request stimulus, csr writes,
// result-side stall, watchdog and verdict.
// Depends on dsc_pkg, divisible_subarray_counter_top and divisible_subarray_counter_checker.
`timescale 1ns / 100ps

module divisible_subarray_counter_top_tb;

   localparam int unsigned QUIET_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 40;

   typedef logic [dsc_pkg::BOX_W-1:0] box_type;
   typedef logic [dsc_pkg::MOD_W-1:0] divisor_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dsc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dsc_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   divisor_type      csr_wr_data = '0;

   int unsigned mismatch_count;
   int unsigned tallies_waiting;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned divisor_now   = 1;
   int unsigned quiet_cycles  = 0;

   divisible_subarray_counter_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   divisible_subarray_counter_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .tallies_waiting (tallies_waiting)
   );

   always #2 clock = ~clock;

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** divisible_subarray_counter_top: FAILED **");
         $finish;
      end
   end

   function automatic dsc_pkg::req_type make_beat(input box_type box, input logic first,
                                                  input logic last);
      dsc_pkg::req_type beat;
      beat.box_count     = box;
      beat.first_of_case = first;
      beat.last_of_case  = last;
      return beat;
   endfunction

   // Favor small values and multiples of the divisor so runs close often
   function automatic box_type pick_box();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 35) return box_type'($urandom_range(15));
      if (sel < 50) return box_type'(divisor_now * $urandom_range(15));
      if (sel < 60) return '0;
      if (sel < 90) return box_type'($urandom);
      return '1;
   endfunction

   function automatic divisor_type pick_divisor();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45) return divisor_type'($urandom_range(12, 1));
      if (sel < 60) return divisor_type'($urandom_range(300, 13));
      if (sel < 68) return '0;
      if (sel < 74) return divisor_type'(1);
      if (sel < 80) return divisor_type'(65536);
      if (sel < 86) return divisor_type'($urandom_range(131071, 65537));
      return divisor_type'($urandom);
   endfunction

   // Offer one request beat and hold it until accepted
   task automatic send_beat(input dsc_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every predicted result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tallies_waiting != 0) @(negedge clock);
   endtask

   // Write the divisor only once the block has gone idle
   task automatic write_divisor(input divisor_type value);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (req_stall) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (value == 0)
         divisor_now = 1;
      else if (value > 65536)
         divisor_now = 65536;
      else
         divisor_now = value;
   endtask

   // Random cases: mostly well-formed, some without a start, without an end, or scrambled
   task automatic run_phase(input int unsigned n_items, input int unsigned snd,
                            input int unsigned rcv);
      int unsigned sent;
      int unsigned cases;
      int unsigned len;
      int unsigned kind;
      int unsigned sel;
      logic        first;
      logic        last;
      bit          mid_change;
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      sent  = 0;
      cases = 0;
      while (sent < n_items) begin
         if (cases % 8 == 0) write_divisor(pick_divisor());
         if (cases == 3) drain_results();
         sel = $urandom_range(99);
         if (sel < 50)
            len = $urandom_range(4, 1);
         else if (sel < 85)
            len = $urandom_range(16, 5);
         else
            len = $urandom_range(60, 17);
         kind = $urandom_range(99);
         mid_change = (kind < 6) && (len > 2);
         for (int unsigned i = 0; i < len; i++) begin
            if (mid_change && i == len / 2) write_divisor(pick_divisor());
            if (kind < 80) begin
               first = (i == 0);
               last  = (i == len - 1);
            end else if (kind < 88) begin
               first = 1'b0;
               last  = (i == len - 1);
            end else if (kind < 94) begin
               first = (i == 0);
               last  = 1'b0;
            end else begin
               first = ($urandom_range(3) == 0);
               last  = ($urandom_range(3) == 0);
            end
            send_beat(make_beat(pick_box(), first, last));
            sent++;
         end
         cases++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 13;
      recv_idle_pct = 76;

      // Beats before any case start, under the reset divisor
      send_beat(make_beat(box_type'(5), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(0), 1'b0, 1'b1));

      // Divisor zero behaves as one; largest value first
      write_divisor(divisor_type'(0));
      send_beat(make_beat('1, 1'b1, 1'b0));
      send_beat(make_beat(box_type'(0), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(1), 1'b0, 1'b1));

      // Largest divisor, with a prefix that wraps to zero
      write_divisor(divisor_type'(65536));
      send_beat(make_beat('1, 1'b1, 1'b0));
      send_beat(make_beat(box_type'(1), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(65536), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(0), 1'b0, 1'b1));

      // Divisor above the limit saturates; one-beat cases
      write_divisor('1);
      send_beat(make_beat(box_type'(12345), 1'b1, 1'b1));
      send_beat(make_beat(box_type'(0), 1'b1, 1'b1));

      // Divisor changed in the middle of a case
      write_divisor(divisor_type'(7));
      send_beat(make_beat(box_type'(3), 1'b1, 1'b0));
      send_beat(make_beat(box_type'(4), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(7), 1'b0, 1'b0));
      write_divisor(divisor_type'(3));
      send_beat(make_beat(box_type'(2), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(1), 1'b0, 1'b0));
      send_beat(make_beat(box_type'('hAAAAA), 1'b0, 1'b1));

      // Divisor one: every run divides
      write_divisor(divisor_type'(1));
      send_beat(make_beat(box_type'('h55555), 1'b1, 1'b0));
      send_beat(make_beat(box_type'(0), 1'b0, 1'b0));
      send_beat(make_beat(box_type'(0), 1'b0, 1'b1));

      run_phase(320, 13, 76);
      run_phase(315, 76, 13);
      run_phase(315, 0, 0);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && tallies_waiting == 0)
         $display("** divisible_subarray_counter_top: PASSED **");
      else
         $display("** divisible_subarray_counter_top: FAILED **");
      $finish;
   end

endmodule
